// File: src/vbrd_pkg.sv
// Shared types and constants for the visibility bitmap run-length decoder.
`timescale 1ns / 1ps
`default_nettype none
package vbrd_pkg;

    // Code byte layout
    localparam int CODE_W        = 8;
    localparam int SKIP_FLAG_BIT = 7;
    localparam int EXT_FLAG_BIT  = 6;
    localparam int SKIP_LOW_W    = 6;
    localparam int MASK_W        = 7;
    localparam int SPAN_W        = 3;
    // Widest skip amount: 14 skip bits plus one
    localparam int SKIP_AMT_W    = 15;

    // Stream framing flags of one transaction
    typedef struct packed {
        logic first;
        logic last;
    } t_flags;

    // Mask of the low span bits of a literal
    function automatic logic [MASK_W-1:0] span_mask(input logic [SPAN_W-1:0] span);
        logic [MASK_W:0] full;
        full = ((MASK_W+1)'(1) << span) - (MASK_W+1)'(1);
        return full[MASK_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: src/vbrd_in_reg.sv
// Input register of the decoder: captures one code byte transaction.
`timescale 1ns / 1ps
`default_nettype none
module vbrd_in_reg #(
    parameter int AREA_INDEX_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [vbrd_pkg::CODE_W-1:0]  i_code,
    input  wire logic [AREA_INDEX_BITS-1:0]   i_area,
    input  wire vbrd_pkg::t_flags             i_flags,
    input  wire logic                         i_take,
    output logic                              o_valid,
    output logic [vbrd_pkg::CODE_W-1:0]       o_code,
    output logic [AREA_INDEX_BITS-1:0]        o_area,
    output vbrd_pkg::t_flags                  o_flags
);
    import vbrd_pkg::*;

    logic                       r_valid;
    logic [CODE_W-1:0]          r_code;
    logic [AREA_INDEX_BITS-1:0] r_area;
    t_flags                     r_flags;
    logic                       load;

    // Hold while the decode stage cannot take the stored transaction
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code  <= i_code;
            r_area  <= i_area;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_area  = r_area;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

// File: src/vbrd_decode.sv
// Decode stage: stream state, run-length decode and result register.
`timescale 1ns / 1ps
`default_nettype none
module vbrd_decode #(
    parameter int AREA_INDEX_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [AREA_INDEX_BITS-1:0]   i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_take,
    input  wire logic [vbrd_pkg::CODE_W-1:0]  i_code,
    input  wire logic [AREA_INDEX_BITS-1:0]   i_area,
    input  wire vbrd_pkg::t_flags             i_flags,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [AREA_INDEX_BITS-1:0]        o_base_area,
    output logic [vbrd_pkg::MASK_W-1:0]       o_visible_mask,
    output logic                              o_done_res
);
    import vbrd_pkg::*;

    localparam int AW = AREA_INDEX_BITS;
    localparam int CW = (AW > SKIP_AMT_W) ? AW : SKIP_AMT_W;

    // Configuration and stream state
    logic [AW-1:0]         r_num_areas;
    logic [AW-1:0]         r_position,  n_position;
    logic                  r_ext,       n_ext;
    logic [SKIP_LOW_W-1:0] r_skip_low,  n_skip_low;
    logic                  r_disabled,  n_disabled;

    // Result register
    logic                  r_out_valid;
    logic [AW-1:0]         r_base;
    logic [MASK_W-1:0]     r_mask;
    logic                  r_done;
    logic [MASK_W-1:0]     n_mask;
    logic                  n_done;

    // Advance the decode stage when the result register is free or draining
    assign o_take = i_valid && (!r_out_valid || !i_stall);

    // Decode one code byte
    always_comb begin
        logic [AW-1:0]         pos;
        logic                  ext;
        logic [SKIP_LOW_W-1:0] low;
        logic                  dis;
        logic [AW-1:0]         room;
        logic [CW-1:0]         amount;
        logic [CW-1:0]         room_x;
        logic [CW-1:0]         step;
        logic [SPAN_W-1:0]     span;
        logic                  do_adv;

        pos    = r_position;
        ext    = r_ext;
        low    = r_skip_low;
        dis    = r_disabled;
        if (i_flags.first) begin
            pos = '0;
            ext = 1'b0;
            low = '0;
            dis = !((i_area != '0) && (i_area < r_num_areas));
        end

        room   = (pos < r_num_areas) ? (r_num_areas - pos) : '0;
        room_x = CW'(room);
        span   = (room < AW'(MASK_W)) ? room[SPAN_W-1:0] : SPAN_W'(MASK_W);
        amount = '0;
        do_adv = 1'b0;
        n_mask = '0;
        n_done = 1'b1;

        if (!dis) begin
            priority if (ext) begin
                // Extension byte holds skip bits 6..13
                ext    = 1'b0;
                amount = CW'({i_code, low}) + CW'(1);
                do_adv = 1'b1;
            end else if (pos >= r_num_areas) begin
                // Past the end: empty mask
                do_adv = 1'b0;
            end else if (i_code[SKIP_FLAG_BIT]) begin
                if (i_code[EXT_FLAG_BIT] && !i_flags.last) begin
                    low = i_code[SKIP_LOW_W-1:0];
                    ext = 1'b1;
                end else begin
                    amount = CW'(i_code[SKIP_LOW_W-1:0]) + CW'(1);
                    do_adv = 1'b1;
                end
            end else begin
                // Literal: drop bits at or beyond the area count
                n_mask = i_code[MASK_W-1:0] & span_mask(span);
                amount = CW'(span);
                do_adv = 1'b1;
            end
        end

        // Saturate the advance at the area count
        step       = (amount > room_x) ? room_x : amount;
        n_position = do_adv ? (pos + step[AW-1:0]) : pos;
        if (!dis) begin
            n_done = i_flags.last || (n_position >= r_num_areas);
        end

        if (i_flags.last) begin
            dis = 1'b1;
            ext = 1'b0;
        end
        n_ext      = ext;
        n_skip_low = low;
        n_disabled = dis;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_areas <= '0;
        end else if (i_cfg_valid) begin
            r_num_areas <= i_cfg_data;
        end
    end

    // Stream state update on each decoded transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_ext      <= 1'b0;
            r_skip_low <= '0;
            r_disabled <= 1'b0;
        end else if (o_take) begin
            r_position <= n_position;
            r_ext      <= n_ext;
            r_skip_low <= n_skip_low;
            r_disabled <= n_disabled;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; base is the position before the byte applies
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_base <= i_flags.first ? '0 : r_position;
            r_mask <= n_mask;
            r_done <= n_done;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_base_area    = r_base;
    assign o_visible_mask = r_mask;
    assign o_done_res     = r_done;

endmodule
`default_nettype wire

// File: src/visibility_bitmap_rle_decoder.sv
// Top level of the visibility bitmap run-length decoder.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_stall| i_code_byte, i_area_number, i_first, i_last
//  out     | output    | o_out_valid / i_out_stall | o_base_area, o_visible_mask, o_done_res
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (num_areas)
//
// One code byte is accepted per cycle while o_in_stall is low; a result passes from its
// transaction through the input register, then through decode into the result register.
// The single decode stage holds the adds, compares and mask logic.
// Reset is synchronous, active low, and clears the area count and stream state.
// A stall on the output holds the result register, then the input register, and
// only then raises o_in_stall.
`timescale 1ns / 1ps
`default_nettype none
module visibility_bitmap_rle_decoder #(
    parameter int AREA_INDEX_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [AREA_INDEX_BITS-1:0]   i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [vbrd_pkg::CODE_W-1:0]  i_code_byte,
    input  wire logic [AREA_INDEX_BITS-1:0]   i_area_number,
    input  wire logic                         i_first,
    input  wire logic                         i_last,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [AREA_INDEX_BITS-1:0]        o_base_area,
    output logic [vbrd_pkg::MASK_W-1:0]       o_visible_mask,
    output logic                              o_done_res
);
    import vbrd_pkg::*;

    t_flags                     in_flags;
    t_flags                     st_flags;
    logic                       st_valid;
    logic                       st_take;
    logic [CODE_W-1:0]          st_code;
    logic [AREA_INDEX_BITS-1:0] st_area;

    assign in_flags.first = i_first;
    assign in_flags.last  = i_last;

    // The user must write configuration only while idle; the block does not enforce this and always takes it
    assign o_cfg_ready = 1'b1;

    vbrd_in_reg #(
        .AREA_INDEX_BITS(AREA_INDEX_BITS)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_code  (i_code_byte),
        .i_area  (i_area_number),
        .i_flags (in_flags),
        .i_take  (st_take),
        .o_valid (st_valid),
        .o_code  (st_code),
        .o_area  (st_area),
        .o_flags (st_flags)
    );

    vbrd_decode #(
        .AREA_INDEX_BITS(AREA_INDEX_BITS)
    ) u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (st_valid),
        .o_take         (st_take),
        .i_code         (st_code),
        .i_area         (st_area),
        .i_flags        (st_flags),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_base_area    (o_base_area),
        .o_visible_mask (o_visible_mask),
        .o_done_res     (o_done_res)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the visibility bitmap run-length decoder.
`timescale 1ns / 1ps
module tb_top;

    import vbrd_pkg::*;

    localparam int          AREA_W          = 16;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          HOLD_OFF_CYCLES = 64;
    localparam int          DRAIN_CYCLES    = 6;
    localparam int          ITEMS_PER_SET   = 122;
    localparam int          NUM_SETTINGS    = 9;
    localparam logic [7:0]  SKIP_FLAG       = 8'(1 << SKIP_FLAG_BIT);
    localparam logic [7:0]  EXT_FLAG        = 8'(1 << EXT_FLAG_BIT);
    localparam logic [7:0]  SKIP_LOW_ALL    = 8'((1 << SKIP_LOW_W) - 1);
    localparam logic [7:0]  LITERAL_ALL     = 8'((1 << MASK_W) - 1);

    // One decoded run: base area, visibility bits and end flag
    typedef struct packed {
        logic [AREA_W-1:0] base;
        logic [MASK_W-1:0] mask;
        logic              done;
    } t_area_run;

    // Tracks decode state and the queue of runs the decoder still owes
    class t_run_tracker;
        logic [AREA_W-1:0]     num_areas;
        logic [AREA_W-1:0]     position;
        logic                  ext_pending;
        logic [SKIP_LOW_W-1:0] skip_low;
        logic                  disabled;
        t_area_run             pending_runs[$];
        int unsigned           errors;

        function new();
            num_areas   = '0;
            position    = '0;
            ext_pending = 1'b0;
            skip_low    = '0;
            disabled    = 1'b0;
            errors      = 0;
        endfunction

        function void set_num_areas(logic [AREA_W-1:0] value);
            num_areas = value;
        endfunction

        // Move forward, stopping at the area count
        function void step_forward(int unsigned amount);
            int unsigned room;
            room = (position < num_areas) ? int'(num_areas) - int'(position) : 0;
            if (amount > room) begin
                amount = room;
            end
            position = AREA_W'(int'(position) + amount);
        endfunction

        function void predict_run(logic [CODE_W-1:0] code, logic [AREA_W-1:0] area,
                                  logic first, logic last);
            t_area_run   run;
            int unsigned room;
            int unsigned span;
            int unsigned span_bits;
            if (first) begin
                position    = '0;
                ext_pending = 1'b0;
                skip_low    = '0;
                disabled    = !(area >= 1 && area < num_areas);
            end
            run.base = position;
            run.mask = '0;
            run.done = 1'b1;
            if (!disabled) begin
                if (ext_pending) begin
                    // This byte carries the high skip bits
                    ext_pending = 1'b0;
                    step_forward(int'({code, skip_low}) + 1);
                end else if (position >= num_areas) begin
                    // Past the end: empty mask
                end else if (code[SKIP_FLAG_BIT]) begin
                    if (code[EXT_FLAG_BIT] && !last) begin
                        skip_low    = code[SKIP_LOW_W-1:0];
                        ext_pending = 1'b1;
                    end else begin
                        step_forward(int'(code[SKIP_LOW_W-1:0]) + 1);
                    end
                end else begin
                    // Literal: clip bits at or beyond the area count
                    room      = int'(num_areas) - int'(position);
                    span      = (room < MASK_W) ? room : MASK_W;
                    span_bits = (1 << span) - 1;
                    run.mask  = code[MASK_W-1:0] & span_bits[MASK_W-1:0];
                    step_forward(span);
                end
                run.done = last || (position >= num_areas);
            end
            if (last) begin
                disabled    = 1'b1;
                ext_pending = 1'b0;
            end
            pending_runs.insert(pending_runs.size(), run);
        endfunction

        function void check_run(logic [AREA_W-1:0] base, logic [MASK_W-1:0] mask,
                                logic done);
            t_area_run want;
            if (pending_runs.size() == 0) begin
                $error("unexpected result: base_area %0d visible_mask %h done_res %0d",
                       base, mask, done);
                errors++;
                return;
            end
            want = pending_runs.pop_front();
            if (base !== want.base) begin
                $error("base_area expected %0d actual %0d", want.base, base);
                errors++;
            end
            if (mask !== want.mask) begin
                $error("visible_mask expected %h actual %h", want.mask, mask);
                errors++;
            end
            if (done !== want.done) begin
                $error("done_res expected %0d actual %0d", want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [AREA_W-1:0]     cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [CODE_W-1:0]     code_byte    = '0;
    logic [AREA_W-1:0]     area_number  = '0;
    logic                  first_flag   = 1'b0;
    logic                  last_flag    = 1'b0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [AREA_W-1:0]     base_area;
    logic [MASK_W-1:0]     visible_mask;
    logic                  done_res;

    t_run_tracker          tracker      = new();
    int unsigned           send_idle_pct = 0;
    int unsigned           recv_idle_pct = 0;
    int unsigned           quiet_cycles  = 0;
    int unsigned           hold_requests = 0;
    int unsigned           hold_served   = 0;
    int unsigned           hold_left     = 0;
    int unsigned           items_sent    = 0;

    visibility_bitmap_rle_decoder #(
        .AREA_INDEX_BITS(AREA_W)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_code_byte    (code_byte),
        .i_area_number  (area_number),
        .i_first        (first_flag),
        .i_last         (last_flag),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_base_area    (base_area),
        .o_visible_mask (visible_mask),
        .o_done_res     (done_res)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Sample every transaction at the edge and count quiet cycles
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                tracker.predict_run(code_byte, area_number, first_flag, last_flag);
            end
            if (out_valid && !out_stall) begin
                tracker.check_run(base_area, visible_mask, done_res);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                    || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Drive the output stall: long hold-off on request, random otherwise
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_OFF_CYCLES - 1;
            out_stall   <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAIL visibility_bitmap_rle_decoder");
        $finish;
    end

    task automatic send_item(input logic [CODE_W-1:0] code, input logic [AREA_W-1:0] area,
                             input logic first, input logic last);
        // Idle the channel at random before offering the byte
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        code_byte   <= code;
        area_number <= area;
        first_flag  <= first;
        last_flag   <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic write_num_areas(input logic [AREA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_num_areas(value);
    endtask

    // Drain all owed runs, then give the pipeline time to settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        // Let the monitor record the transaction accepted at this edge
        @(posedge clk);
        while (tracker.pending_runs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [AREA_W-1:0] pick_area();
        int unsigned n;
        n = tracker.num_areas;
        if (n >= 2 && $urandom_range(99) < 92) begin
            return AREA_W'($urandom_range(n - 1, 1));
        end
        if ($urandom_range(1) == 0) begin
            return '0;
        end
        return AREA_W'($urandom_range(16'hFFFF, n));
    endfunction

    // Well-formed stream: first byte, mix of literals and skips, last byte
    task automatic send_stream();
        int unsigned       len;
        int unsigned       idx;
        int unsigned       pick;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] high;
        len = $urandom_range(24, 1);
        idx = 0;
        while (idx < len) begin
            pick = $urandom_range(99);
            high = ($urandom_range(99) < 80) ? CODE_W'($urandom_range(3))
                                              : CODE_W'($urandom);
            if (pick < 45) begin
                code = CODE_W'($urandom) & LITERAL_ALL;
            end else if (pick < 75) begin
                code = SKIP_FLAG | (CODE_W'($urandom) & SKIP_LOW_ALL);
            end else if (pick < 95) begin
                code = SKIP_FLAG | EXT_FLAG | (CODE_W'($urandom) & SKIP_LOW_ALL);
            end else begin
                code = CODE_W'($urandom);
            end
            send_item(code, (idx == 0) ? pick_area() : AREA_W'($urandom),
                      idx == 0, idx == len - 1);
            idx++;
            // Follow an extended skip with its high byte
            if (pick >= 75 && pick < 95 && idx < len) begin
                send_item(high, AREA_W'($urandom), 1'b0, idx == len - 1);
                idx++;
            end
        end
    endtask

    task automatic run_directed();
        // No first byte after reset: decode from position zero
        send_item(LITERAL_ALL, '0, 1'b0, 1'b0);
        send_item(SKIP_FLAG | EXT_FLAG | 8'd1, 16'hFFFF, 1'b0, 1'b0);
        send_item(8'd2, '0, 1'b0, 1'b0);
        // Normal stream with literals, short and extended skips
        send_item(8'h2A, 16'd5, 1'b1, 1'b0);
        send_item(SKIP_FLAG | EXT_FLAG, '0, 1'b0, 1'b0);
        send_item(8'h00, '0, 1'b0, 1'b0);
        send_item(SKIP_FLAG | 8'd5, '0, 1'b0, 1'b0);
        // Largest extended skip runs past the end
        send_item(SKIP_FLAG | EXT_FLAG | SKIP_LOW_ALL, '0, 1'b0, 1'b0);
        send_item(8'hFF, '0, 1'b0, 1'b0);
        send_item(LITERAL_ALL, '0, 1'b0, 1'b1);
        // Byte after the last one
        send_item(LITERAL_ALL, '0, 1'b0, 1'b0);
        // Extension flag on the final byte uses the low bits alone
        send_item(SKIP_FLAG | EXT_FLAG | SKIP_LOW_ALL, 16'd12, 1'b1, 1'b1);
        // Bad area numbers: zero, equal to the count, all ones
        send_item(LITERAL_ALL, '0, 1'b1, 1'b0);
        send_item(8'd1, '0, 1'b0, 1'b1);
        send_item(8'h55, 16'd40, 1'b1, 1'b1);
        send_item(8'h00, 16'hFFFF, 1'b1, 1'b0);
        // Literal near the end gets clipped
        send_item(SKIP_FLAG | 8'd35, 16'd39, 1'b1, 1'b0);
        send_item(LITERAL_ALL, '0, 1'b0, 1'b0);
        send_item(8'h00, '0, 1'b0, 1'b1);
        send_item(8'h00, 16'd1, 1'b1, 1'b0);
        send_item(LITERAL_ALL, '0, 1'b0, 1'b1);
    endtask

    initial begin
        logic [AREA_W-1:0] settings [NUM_SETTINGS];
        int unsigned       budget;
        settings = '{16'd300, 16'd0, 16'hFFFF, 16'd7, 16'd1, 16'd9000,
                     16'd2, 16'hFFFF, 16'd40};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 73;
        write_num_areas(16'd40);
        run_directed();

        for (int k = 0; k < NUM_SETTINGS; k++) begin
            wait_idle();
            // Swap idling roles after three settings, then stop idling
            if (k == 3) begin
                send_idle_pct = 73;
                recv_idle_pct = 37;
            end else if (k == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_requests++;
            end
            write_num_areas(settings[k]);
            budget = items_sent + ITEMS_PER_SET;
            while (items_sent < budget) begin
                if ($urandom_range(99) < 85) begin
                    send_stream();
                end else begin
                    send_item(CODE_W'($urandom), AREA_W'($urandom),
                              $urandom_range(99) < 10, $urandom_range(99) < 10);
                end
            end
        end

        wait_idle();
        if (tracker.errors == 0) begin
            $display("PASS visibility_bitmap_rle_decoder");
        end else begin
            $display("FAIL visibility_bitmap_rle_decoder");
        end
        $finish;
    end

endmodule
